[hdl/lcm_pkg.sv]
// Package: shared types, constants and the state enum for the LUT cut merge mapper.
`default_nettype none
package lcm_pkg;
	localparam int unsigned MAX_NODES_D  = 16384;
	localparam int unsigned MAX_LEAVES_D = 8;
	localparam int unsigned LEVEL_BITS_D = 10;
	localparam int unsigned ID_W         = 14;
	localparam int unsigned LEAVES       = 8;
	localparam int unsigned CNT_W        = 4;
	localparam int unsigned LVL_W        = 10;
	localparam logic [CNT_W-1:0] K_RESET = 4'd8;

	typedef enum logic [1:0] {
		MODE_INIT = 2'd0,
		MODE_MAP  = 2'd1,
		MODE_READ = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]      mode;
		logic [ID_W-1:0] node_id;
		logic [ID_W-1:0] fanin0_id;
		logic [ID_W-1:0] fanin1_id;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]  leaf_0;
		logic [ID_W-1:0]  leaf_1;
		logic [ID_W-1:0]  leaf_2;
		logic [ID_W-1:0]  leaf_3;
		logic [ID_W-1:0]  leaf_4;
		logic [ID_W-1:0]  leaf_5;
		logic [ID_W-1:0]  leaf_6;
		logic [ID_W-1:0]  leaf_7;
		logic [CNT_W-1:0] leaf_count;
		logic [LVL_W-1:0] level;
		logic             merged;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_WAIT,
		ST_PREP,
		ST_SWAP,
		ST_SUB,
		ST_MERGE,
		ST_FINAL,
		ST_WRITE,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

[hdl/lcm_store.sv]
// Node table memory: leaf ids, leaf count and level per node, one port.
`default_nettype none
module lcm_store #(
	parameter int unsigned MAX_NODES  = lcm_pkg::MAX_NODES_D,
	parameter int unsigned MAX_LEAVES = lcm_pkg::MAX_LEAVES_D,
	parameter int unsigned LEVEL_BITS = lcm_pkg::LEVEL_BITS_D
) (
	input  wire                                       clk,
	input  wire                                       we,
	input  wire  [$clog2(MAX_NODES)-1:0]              addr,
	input  wire  [MAX_LEAVES*lcm_pkg::ID_W-1:0]       wleaves,
	input  wire  [lcm_pkg::CNT_W-1:0]                 wcount,
	input  wire  [LEVEL_BITS-1:0]                     wlevel,
	output logic [MAX_LEAVES*lcm_pkg::ID_W-1:0]       rleaves,
	output logic [lcm_pkg::CNT_W-1:0]                 rcount,
	output logic [LEVEL_BITS-1:0]                     rlevel
);
	localparam int unsigned W = MAX_LEAVES*lcm_pkg::ID_W + lcm_pkg::CNT_W + LEVEL_BITS;
	logic [W-1:0] mem [MAX_NODES];
	logic [W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= {wleaves, wcount, wlevel};
		end
		rd_q <= mem[addr];
	end

	assign {rleaves, rcount, rlevel} = rd_q;
endmodule
`default_nettype wire

[hdl/lcm_core.sv]
// Sequencer and shared compare unit for the sorted bounded cut merge.
`default_nettype none
module lcm_core #(
	parameter int unsigned MAX_NODES  = lcm_pkg::MAX_NODES_D,
	parameter int unsigned MAX_LEAVES = lcm_pkg::MAX_LEAVES_D,
	parameter int unsigned LEVEL_BITS = lcm_pkg::LEVEL_BITS_D
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  lcm_pkg::item_t           item,
	input  wire  [lcm_pkg::CNT_W-1:0] k_raw,
	output logic                     busy,
	output logic                     done,
	output lcm_pkg::result_t         result
);
	localparam int unsigned AW = $clog2(MAX_NODES);
	localparam int unsigned IW = lcm_pkg::ID_W;
	localparam int unsigned CW = lcm_pkg::CNT_W;
	localparam int unsigned LW = LEVEL_BITS;
	localparam int unsigned PW = $clog2(MAX_LEAVES) + 1;
	localparam logic [LW-1:0] LVL_MAX = {LW{1'b1}};
	localparam logic [CW-1:0] MAXL = CW'(MAX_LEAVES);

	lcm_pkg::state_t state_q, state_d;
	lcm_pkg::item_t  item_q;
	logic [CW-1:0]   k_q;

	logic [IW-1:0] a_q [MAX_LEAVES];
	logic [IW-1:0] b_q [MAX_LEAVES];
	logic [IW-1:0] r_q [MAX_LEAVES];
	logic [CW-1:0] na_q, nb_q, nr_q;
	logic [LW-1:0] la_q, lb_q, lv_q;
	logic [PW-1:0] i_q, j_q, c_q;
	logic          ok_q, merged_q, sub_q;

	logic                        we;
	logic [AW-1:0]               addr;
	logic [MAX_LEAVES*IW-1:0]    wleaves, rleaves;
	logic [CW-1:0]               wcount, rcount;
	logic [LW-1:0]               wlevel, rlevel;

	lcm_store #(.MAX_NODES(MAX_NODES), .MAX_LEAVES(MAX_LEAVES), .LEVEL_BITS(LEVEL_BITS))
	u_store (
		.clk(clk), .we(we), .addr(addr), .wleaves(wleaves), .wcount(wcount),
		.wlevel(wlevel), .rleaves(rleaves), .rcount(rcount), .rlevel(rlevel)
	);

	logic [CW-1:0] rcount_c;
	assign rcount_c = (rcount > MAXL) ? MAXL : rcount;

	always_comb begin
		for (int n = 0; n < MAX_LEAVES; n++) begin
			wleaves[n*IW +: IW] = r_q[n];
		end
		wcount = nr_q;
		wlevel = lv_q;
	end

	// shared compare unit
	logic [IW-1:0] ai, bj;
	logic          a_end, b_end, a_lt, a_gt;
	assign ai    = a_q[i_q[PW-2:0]];
	assign bj    = b_q[j_q[PW-2:0]];
	assign a_end = ({{(CW-PW+1){1'b0}}, i_q} >= {1'b0, na_q});
	assign b_end = ({{(CW-PW+1){1'b0}}, j_q} >= {1'b0, nb_q});
	assign a_lt  = ai < bj;
	assign a_gt  = ai > bj;

	logic hit;
	always_comb begin
		hit = 1'b0;
		for (int n = 0; n < MAX_LEAVES; n++) begin
			if (CW'(n) < na_q && a_q[n] == bj) begin
				hit = 1'b1;
			end
		end
	end

	logic [CW-1:0] k_eff;
	assign k_eff = (k_q < CW'(2)) ? CW'(2) : ((k_q > MAXL) ? MAXL : k_q);

	logic [CW-1:0] wider;
	logic          match;
	assign wider = (na_q < nb_q) ? nb_q : na_q;
	assign match = (nb_q == k_eff) ? (a_q[j_q[PW-2:0]] == bj) : hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = (state_q != lcm_pkg::ST_IDLE);
		done    = (state_q == lcm_pkg::ST_OUT);
		we      = 1'b0;
		addr    = AW'(item_q.node_id);
		unique case (state_q)
			lcm_pkg::ST_IDLE: begin
				addr = AW'(item.node_id);
				if (start) begin
					state_d = (item.mode == lcm_pkg::MODE_MAP) ? lcm_pkg::ST_RD0
						: ((item.mode == lcm_pkg::MODE_INIT) ? lcm_pkg::ST_WRITE
						: lcm_pkg::ST_WAIT);
				end
			end
			lcm_pkg::ST_RD0: begin
				addr    = AW'(item_q.fanin0_id);
				state_d = lcm_pkg::ST_RD1;
			end
			lcm_pkg::ST_RD1: begin
				addr    = AW'(item_q.fanin1_id);
				state_d = lcm_pkg::ST_WAIT;
			end
			lcm_pkg::ST_WAIT: begin
				state_d = (item_q.mode == lcm_pkg::MODE_MAP) ? lcm_pkg::ST_PREP
					: lcm_pkg::ST_OUT;
			end
			lcm_pkg::ST_PREP: state_d = lcm_pkg::ST_SWAP;
			lcm_pkg::ST_SWAP: begin
				state_d = (wider == k_eff) ? lcm_pkg::ST_SUB : lcm_pkg::ST_MERGE;
			end
			lcm_pkg::ST_SUB: begin
				if (b_end || !match) begin
					state_d = lcm_pkg::ST_FINAL;
				end
			end
			lcm_pkg::ST_MERGE: begin
				if ((a_end && b_end) || c_q[PW-1:0] >= PW'(k_eff)) begin
					state_d = lcm_pkg::ST_FINAL;
				end
			end
			lcm_pkg::ST_FINAL: state_d = lcm_pkg::ST_WRITE;
			lcm_pkg::ST_WRITE: begin
				we      = 1'b1;
				state_d = lcm_pkg::ST_OUT;
			end
			lcm_pkg::ST_OUT:  state_d = lcm_pkg::ST_IDLE;
			default:          state_d = lcm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lcm_pkg::ST_IDLE: begin
				item_q   <= item;
				k_q      <= k_raw;
				merged_q <= 1'b0;
				for (int n = 0; n < MAX_LEAVES; n++) begin
					r_q[n] <= '0;
				end
				r_q[0] <= item.node_id;
				nr_q   <= CW'(1);
				lv_q   <= '0;
			end
			lcm_pkg::ST_RD1: begin
				for (int n = 0; n < MAX_LEAVES; n++) begin
					a_q[n] <= rleaves[n*IW +: IW];
				end
				na_q <= rcount_c;
				la_q <= rlevel;
			end
			lcm_pkg::ST_WAIT: begin
				if (item_q.mode == lcm_pkg::MODE_MAP) begin
					for (int n = 0; n < MAX_LEAVES; n++) begin
						b_q[n] <= rleaves[n*IW +: IW];
						r_q[n] <= '0;
					end
					nb_q <= rcount_c;
					lb_q <= rlevel;
				end else begin
					for (int n = 0; n < MAX_LEAVES; n++) begin
						r_q[n] <= (CW'(n) < rcount_c) ? rleaves[n*IW +: IW] : '0;
					end
					nr_q <= rcount_c;
					lv_q <= rlevel;
				end
			end
			lcm_pkg::ST_PREP: begin
				i_q <= '0;
				j_q <= '0;
				c_q <= '0;
				ok_q <= 1'b1;
				if (la_q == lb_q) begin
					lv_q <= (la_q == '0) ? LW'(1) : la_q;
				end else if (la_q > lb_q) begin
					lv_q   <= la_q;
					b_q[0] <= item_q.fanin1_id;
					nb_q   <= CW'(1);
				end else begin
					lv_q   <= lb_q;
					a_q[0] <= item_q.fanin0_id;
					na_q   <= CW'(1);
				end
			end
			lcm_pkg::ST_SWAP: begin
				// keep the larger set in a
				if (na_q < nb_q) begin
					for (int n = 0; n < MAX_LEAVES; n++) begin
						a_q[n] <= b_q[n];
						b_q[n] <= a_q[n];
					end
					na_q <= nb_q;
					nb_q <= na_q;
				end
			end
			lcm_pkg::ST_SUB: begin
				// match b against a: element by element when both are full, else as a subset
				if (!b_end) begin
					if (!match) begin
						ok_q <= 1'b0;
					end
					j_q <= j_q + PW'(1);
				end
				sub_q <= 1'b1;
			end
			lcm_pkg::ST_MERGE: begin
				sub_q <= 1'b0;
				if (!(a_end && b_end) && c_q[PW-1:0] < PW'(k_eff)) begin
					c_q <= c_q + PW'(1);
					if (b_end || (!a_end && a_lt)) begin
						r_q[c_q[PW-2:0]] <= ai;
						i_q <= i_q + PW'(1);
					end else if (a_end || a_gt) begin
						r_q[c_q[PW-2:0]] <= bj;
						j_q <= j_q + PW'(1);
					end else begin
						r_q[c_q[PW-2:0]] <= ai;
						i_q <= i_q + PW'(1);
						j_q <= j_q + PW'(1);
					end
				end else if (!(a_end && b_end)) begin
					ok_q <= 1'b0;
				end
			end
			lcm_pkg::ST_FINAL: begin
				if (sub_q && ok_q) begin
					for (int n = 0; n < MAX_LEAVES; n++) begin
						r_q[n] <= (CW'(n) < na_q) ? a_q[n] : '0;
					end
					nr_q     <= na_q;
					merged_q <= 1'b1;
				end else if (!sub_q && ok_q) begin
					nr_q     <= CW'(c_q);
					merged_q <= 1'b1;
				end else begin
					for (int n = 0; n < MAX_LEAVES; n++) begin
						r_q[n] <= '0;
					end
					r_q[0] <= (item_q.fanin0_id < item_q.fanin1_id)
						? item_q.fanin0_id : item_q.fanin1_id;
					r_q[1] <= (item_q.fanin0_id < item_q.fanin1_id)
						? item_q.fanin1_id : item_q.fanin0_id;
					nr_q <= CW'(2);
					if (lv_q != LVL_MAX) begin
						lv_q <= lv_q + LW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result            = '0;
		result.leaf_0     = r_q[0];
		result.leaf_1     = r_q[1];
		result.leaf_2     = (MAX_LEAVES > 2) ? r_q[2 % MAX_LEAVES] : '0;
		result.leaf_3     = (MAX_LEAVES > 3) ? r_q[3 % MAX_LEAVES] : '0;
		result.leaf_4     = (MAX_LEAVES > 4) ? r_q[4 % MAX_LEAVES] : '0;
		result.leaf_5     = (MAX_LEAVES > 5) ? r_q[5 % MAX_LEAVES] : '0;
		result.leaf_6     = (MAX_LEAVES > 6) ? r_q[6 % MAX_LEAVES] : '0;
		result.leaf_7     = (MAX_LEAVES > 7) ? r_q[7 % MAX_LEAVES] : '0;
		result.leaf_count = nr_q;
		result.level      = lcm_pkg::LVL_W'(lv_q);
		result.merged     = merged_q;
	end
endmodule
`default_nettype wire

[hdl/lut_cut_merge_mapper.sv]
// Top level: LUT cut merge mapper with its K register.
// Map: two table reads, level and swap, merge or compare steps, write-back.
// Throughput: one item at a time; busy stays high up to and including the strobe cycle.
// Reset clears the sequencer and sets K to 8; the node table is not cleared.
// The result is shown for one cycle on done; the receiver cannot stall.
`default_nettype none
module lut_cut_merge_mapper #(
	parameter int unsigned MAX_NODES  = lcm_pkg::MAX_NODES_D,
	parameter int unsigned MAX_LEAVES = lcm_pkg::MAX_LEAVES_D,
	parameter int unsigned LEVEL_BITS = lcm_pkg::LEVEL_BITS_D
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  lcm_pkg::item_t           item,
	output logic                     done,
	output lcm_pkg::result_t         result,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire  [lcm_pkg::CNT_W-1:0] cfg_data
);
	logic [lcm_pkg::CNT_W-1:0] k_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= lcm_pkg::K_RESET;
		end else if (cfg_valid && cfg_ready) begin
			k_q <= cfg_data;
		end
	end

	lcm_core #(.MAX_NODES(MAX_NODES), .MAX_LEAVES(MAX_LEAVES), .LEVEL_BITS(LEVEL_BITS))
	u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .k_raw(k_q),
		.busy(busy), .done(done), .result(result)
	);
endmodule
`default_nettype wire

[verif/testbench.sv]
// Testbench for lut_cut_merge_mapper: cut table predictor, scoreboard, directed and random items.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	localparam int unsigned LIMIT = 1000000;
	localparam int unsigned SETTLE = 30;
	localparam int unsigned IW = lcm_pkg::ID_W;
	localparam int unsigned CW = lcm_pkg::CNT_W;
	localparam int unsigned LW = lcm_pkg::LVL_W;
	localparam int unsigned NL = lcm_pkg::LEAVES;
	localparam int unsigned NODES = lcm_pkg::MAX_NODES_D;
	localparam int unsigned LVL_MAX = (1 << lcm_pkg::LEVEL_BITS_D) - 1;

	typedef logic [IW-1:0] leaf_arr_t [NL];

	class cut_scoreboard;
		logic [IW-1:0]     leaf_tab [NODES][NL];
		logic [CW-1:0]     count_tab [NODES];
		logic [LW-1:0]     level_tab [NODES];
		logic [CW-1:0]     k_reg;
		lcm_pkg::result_t  cut_q [$];
		int                errors;

		function new();
			k_reg = lcm_pkg::K_RESET;
			errors = 0;
		endfunction

		function automatic bit merge(input leaf_arr_t a, input int na, input leaf_arr_t b,
				input int nb, input int k, output leaf_arr_t o, output int no);
			int i;
			int j;
			int c;
			bit found;
			for (c = 0; c < NL; c++) o[c] = '0;
			no = 0;
			if (na == k && nb == k) begin
				for (i = 0; i < na; i++) if (a[i] != b[i]) return 0;
				for (i = 0; i < na; i++) o[i] = a[i];
				no = na;
				return 1;
			end
			if (na == k) begin
				for (i = 0; i < nb; i++) begin
					found = 0;
					for (j = 0; j < na; j++) if (a[j] == b[i]) found = 1;
					if (!found) return 0;
				end
				for (i = 0; i < na; i++) o[i] = a[i];
				no = na;
				return 1;
			end
			i = 0;
			j = 0;
			for (c = 0; c < k; c++) begin
				if (j == nb) begin
					if (i == na) begin
						no = c;
						return 1;
					end
					o[c] = a[i];
					i++;
				end else if (i == na) begin
					o[c] = b[j];
					j++;
				end else if (a[i] < b[j]) begin
					o[c] = a[i];
					i++;
				end else if (a[i] > b[j]) begin
					o[c] = b[j];
					j++;
				end else begin
					o[c] = a[i];
					i++;
					j++;
				end
			end
			if (i < na || j < nb) return 0;
			no = k;
			return 1;
		endfunction

		function automatic void note_item(lcm_pkg::item_t it);
			leaf_arr_t a;
			leaf_arr_t b;
			leaf_arr_t r;
			int na;
			int nb;
			int nr;
			int k;
			int lv;
			int l0;
			int l1;
			int n;
			bit ok;
			bit mrg;
			lcm_pkg::result_t res;
			mrg = 0;
			res = '0;
			k = int'(k_reg);
			if (k < 2) k = 2;
			if (k > lcm_pkg::MAX_LEAVES_D) k = lcm_pkg::MAX_LEAVES_D;
			if (lcm_pkg::mode_t'(it.mode) == lcm_pkg::MODE_INIT) begin
				for (int i = 0; i < NL; i++) leaf_tab[it.node_id][i] = '0;
				leaf_tab[it.node_id][0] = it.node_id;
				count_tab[it.node_id] = CW'(1);
				level_tab[it.node_id] = '0;
			end else if (lcm_pkg::mode_t'(it.mode) == lcm_pkg::MODE_MAP) begin
				for (int i = 0; i < NL; i++) begin
					a[i] = leaf_tab[it.fanin0_id][i];
					b[i] = leaf_tab[it.fanin1_id][i];
				end
				na = (count_tab[it.fanin0_id] > NL) ? NL : int'(count_tab[it.fanin0_id]);
				nb = (count_tab[it.fanin1_id] > NL) ? NL : int'(count_tab[it.fanin1_id]);
				l0 = int'(level_tab[it.fanin0_id]);
				l1 = int'(level_tab[it.fanin1_id]);
				if (l0 == l1) begin
					lv = (l0 == 0) ? 1 : l0;
				end else if (l0 > l1) begin
					lv = l0;
					b[0] = it.fanin1_id;
					nb = 1;
				end else begin
					lv = l1;
					a[0] = it.fanin0_id;
					na = 1;
				end
				if (lv > LVL_MAX) lv = LVL_MAX;
				if (na < nb) ok = merge(b, nb, a, na, k, r, nr);
				else ok = merge(a, na, b, nb, k, r, nr);
				if (!ok) begin
					if (lv < LVL_MAX) lv++;
					for (int i = 0; i < NL; i++) r[i] = '0;
					r[0] = (it.fanin0_id < it.fanin1_id) ? it.fanin0_id : it.fanin1_id;
					r[1] = (it.fanin0_id < it.fanin1_id) ? it.fanin1_id : it.fanin0_id;
					nr = 2;
				end else begin
					mrg = 1;
				end
				for (int i = 0; i < NL; i++) leaf_tab[it.node_id][i] = (i < nr) ? r[i] : '0;
				count_tab[it.node_id] = CW'(nr);
				level_tab[it.node_id] = LW'(lv);
			end
			n = (count_tab[it.node_id] > NL) ? NL : int'(count_tab[it.node_id]);
			for (int i = 0; i < NL; i++) r[i] = (i < n) ? leaf_tab[it.node_id][i] : '0;
			res.leaf_0 = r[0];
			res.leaf_1 = r[1];
			res.leaf_2 = r[2];
			res.leaf_3 = r[3];
			res.leaf_4 = r[4];
			res.leaf_5 = r[5];
			res.leaf_6 = r[6];
			res.leaf_7 = r[7];
			res.leaf_count = CW'(n);
			res.level = level_tab[it.node_id];
			res.merged = mrg;
			cut_q.push_back(res);
		endfunction

		function automatic void check_result(lcm_pkg::result_t got);
			lcm_pkg::result_t want;
			if (cut_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			want = cut_q.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	lcm_pkg::item_t   item;
	logic             done;
	lcm_pkg::result_t result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CW-1:0]    cfg_data;

	cut_scoreboard    sb;
	bit               written [NODES];
	logic [IW-1:0]    known_q [$];
	bit               quiet;
	int unsigned      cycles;

	lut_cut_merge_mapper u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("lut_cut_merge_mapper verification failed");
			$finish;
		end
	end

	always @(posedge clk) if (arst_n && done) sb.check_result(result);

	function automatic int idle_len();
		int n;
		n = 0;
		if (!quiet) while ($urandom_range(99) < 33) n++;
		return n;
	endfunction

	task automatic send(input lcm_pkg::mode_t m, input logic [IW-1:0] nid,
			input logic [IW-1:0] f0, input logic [IW-1:0] f1);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		item <= '{mode: m, node_id: nid, fanin0_id: f0, fanin1_id: f1};
		do @(posedge clk); while (busy);
		sb.note_item('{mode: m, node_id: nid, fanin0_id: f0, fanin1_id: f1});
		if (m != lcm_pkg::MODE_READ && m != lcm_pkg::MODE_RSVD && !written[nid]) begin
			written[nid] = 1;
			known_q.push_back(nid);
		end
	endtask

	task automatic set_k(input logic [CW-1:0] v);
		start <= 0;
		@(posedge clk);
		while (sb.cut_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.k_reg = v;
	endtask

	function automatic logic [IW-1:0] pick();
		return known_q[$urandom_range(known_q.size() - 1)];
	endfunction

	task automatic random_items(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 12) send(lcm_pkg::MODE_INIT, IW'($urandom), 0, 0);
			else if (r < 80) send(lcm_pkg::MODE_MAP, (r < 50) ? pick() : IW'($urandom),
				pick(), pick());
			else if (r < 92) send(lcm_pkg::MODE_READ, pick(), IW'($urandom), IW'($urandom));
			else send(lcm_pkg::MODE_RSVD, pick(), IW'($urandom), IW'($urandom));
		end
	endtask

	task automatic level_climb(input int rounds);
		logic [IW-1:0] p;
		logic [IW-1:0] q;
		logic [IW-1:0] s;
		logic [IW-1:0] base;
		send(lcm_pkg::MODE_INIT, 200, 0, 0);
		send(lcm_pkg::MODE_INIT, 201, 0, 0);
		send(lcm_pkg::MODE_INIT, 202, 0, 0);
		p = 200;
		q = 201;
		s = 202;
		for (int i = 0; i < rounds; i++) begin
			base = (i % 2) ? IW'(210) : IW'(220);
			send(lcm_pkg::MODE_MAP, base, p, q);
			send(lcm_pkg::MODE_MAP, IW'(base + 1), q, s);
			send(lcm_pkg::MODE_MAP, IW'(base + 2), p, s);
			p = base;
			q = IW'(base + 1);
			s = IW'(base + 2);
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		quiet = 0;
		arst_n = 0;
		start = 0;
		item = '0;
		cfg_valid = 0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(lcm_pkg::MODE_INIT, 0, 0, 0);
		send(lcm_pkg::MODE_INIT, 16383, 16383, 16383);
		send(lcm_pkg::MODE_INIT, 5, 0, 0);
		send(lcm_pkg::MODE_INIT, 9, 0, 0);
		send(lcm_pkg::MODE_MAP, 100, 5, 9);
		send(lcm_pkg::MODE_MAP, 101, 16383, 0);
		send(lcm_pkg::MODE_MAP, 102, 100, 101);
		send(lcm_pkg::MODE_MAP, 103, 102, 5);
		send(lcm_pkg::MODE_MAP, 104, 100, 100);
		send(lcm_pkg::MODE_MAP, 105, 5, 5);
		send(lcm_pkg::MODE_READ, 102, 16383, 16383);
		send(lcm_pkg::MODE_RSVD, 16383, 0, 0);
		set_k(2);
		send(lcm_pkg::MODE_MAP, 106, 102, 101);
		send(lcm_pkg::MODE_MAP, 107, 102, 102);
		send(lcm_pkg::MODE_MAP, 108, 103, 103);
		send(lcm_pkg::MODE_MAP, 109, 9, 16383);
		set_k(0);
		send(lcm_pkg::MODE_MAP, 110, 102, 100);
		set_k(15);
		send(lcm_pkg::MODE_MAP, 111, 102, 109);
		send(lcm_pkg::MODE_MAP, 112, 111, 110);

		random_items(150);
		set_k(2);
		quiet = 1;
		random_items(100);
		quiet = 0;
		level_climb(40);
		set_k(1);
		random_items(100);
		set_k(4);
		random_items(100);
		set_k(8);
		random_items(100);
		set_k(CW'($urandom_range(2, 8)));
		random_items(100);

		start <= 0;
		@(posedge clk);
		while (sb.cut_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0)
			$display("lut_cut_merge_mapper verification clean");
		else
			$display("lut_cut_merge_mapper verification failed");
		$finish;
	end
endmodule
`default_nettype wire

[lut_cut_merge_mapper.f]
hdl/lcm_pkg.sv
hdl/lcm_store.sv
hdl/lcm_core.sv
hdl/lut_cut_merge_mapper.sv
verif/testbench.sv
